// ----- src/erni_pkg.sv -----
// Package with shared types and constants for the eigenpair residual norm block.
`default_nettype none
package erni_pkg;
    localparam int MaxRows = 4096;
    localparam int RowW = $clog2(MaxRows);
    localparam int QueueDepth = 2;

    // Per-mode summary handed from the accumulator to the finisher.
    typedef struct packed {
        logic [63:0]     residual_sum;
        logic [63:0]     stiffness_sum;
        logic [63:0]     mass_sum;
        logic [31:0]     lambda_mag;
        logic [RowW-1:0] worst_index;
        logic            last_mode;
    } mode_sum_t;

    typedef enum logic [2:0] {
        FIN_IDLE,
        FIN_SQRT,
        FIN_MUL,
        FIN_DIV,
        FIN_OUT
    } fin_state_t;
endpackage
`default_nettype wire

// ----- src/erni_accum.sv -----
// Front part: per-row residual, sums of squares, worst row tracking.
`default_nettype none
module erni_accum (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                row_valid,
    output logic                     row_ready,
    input  wire logic signed [31:0]  stiffness_action,
    input  wire logic signed [31:0]  mass_action,
    input  wire logic signed [31:0]  eigenvalue,
    input  wire logic                last_row,
    input  wire logic [10:0]         mode_count,
    output logic                     sum_valid,
    input  wire logic                sum_ready,
    output erni_pkg::mode_sum_t      sum_data
);
    import erni_pkg::*;

    // Stage 1 registers: products.
    logic               s1_valid_reg;
    logic signed [63:0] kscaled_reg, lm_reg;
    logic [63:0]        ksq_reg, msq_reg;
    logic [31:0]        lmag_reg;
    logic               s1_last_reg;
    // Stage 2 registers: rounded residual magnitude.
    logic               s2_valid_reg;
    logic [48:0]        s2_rmag_reg;
    logic [63:0]        s2_ksq_reg, s2_msq_reg;
    logic [31:0]        s2_lmag_reg;
    logic               s2_last_reg;
    // Stage 3: accumulate.
    logic [63:0] rsum_reg, ksum_reg, msum_reg;
    logic [31:0] worst_mag_reg;
    logic        worst_seen_reg;
    logic [RowW-1:0] worst_idx_reg, row_idx_reg;
    logic [9:0]  modes_done_reg;
    logic        out_valid_reg;
    mode_sum_t   out_reg;

    logic s1_go, acc_stall, acc_go;
    logic [31:0] kmag, mmag;
    logic signed [64:0] rfull;
    logic [64:0] rabs;
    logic [48:0] rmag;
    logic [63:0] rsq;
    logic [31:0] rsat;
    logic [64:0] radd, kadd, madd;
    logic [63:0] rsum_n, ksum_n, msum_n;
    logic [10:0] limit, count;
    logic        lastmode;
    logic        take_worst;

    // Output holds a finished mode until the queue takes it.
    assign acc_stall = out_valid_reg && !sum_ready && s2_valid_reg && s2_last_reg;
    assign row_ready = !acc_stall;
    assign s1_go = row_valid && row_ready;
    assign acc_go = s2_valid_reg && !acc_stall;

    assign kmag = stiffness_action[31] ? 32'(-stiffness_action) : stiffness_action;
    assign mmag = mass_action[31] ? 32'(-mass_action) : mass_action;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (row_ready)
        begin
            s1_valid_reg <= s1_go;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            kscaled_reg <= 64'(stiffness_action) <<< 16;
            lm_reg      <= 64'(eigenvalue) * 64'(mass_action);
            ksq_reg     <= 64'(kmag) * 64'(kmag);
            msq_reg     <= 64'(mmag) * 64'(mmag);
            lmag_reg    <= eigenvalue[31] ? 32'(-eigenvalue) : eigenvalue;
            s1_last_reg <= last_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_ready && s1_valid_reg)
        begin
            s2_rmag_reg <= rmag;
            s2_ksq_reg  <= ksq_reg;
            s2_msq_reg  <= msq_reg;
            s2_lmag_reg <= lmag_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    always_comb
    begin
        rfull = 65'(kscaled_reg) - 65'(lm_reg);
        rabs  = rfull[64] ? 65'(-rfull) : rfull;
        rmag  = 49'((rabs + 65'd32768) >> 16);
        rsq   = (s2_rmag_reg[48:32] != '0) ? '1 :
                64'(s2_rmag_reg[31:0]) * 64'(s2_rmag_reg[31:0]);
        rsat  = (s2_rmag_reg[48:32] != '0) ? '1 : s2_rmag_reg[31:0];
        radd  = 65'(rsum_reg) + 65'(rsq);
        kadd  = 65'(ksum_reg) + 65'(s2_ksq_reg);
        madd  = 65'(msum_reg) + 65'(s2_msq_reg);
        rsum_n = radd[64] ? '1 : radd[63:0];
        ksum_n = kadd[64] ? '1 : kadd[63:0];
        msum_n = madd[64] ? '1 : madd[63:0];
        take_worst = !worst_seen_reg || (rsat > worst_mag_reg);
        if (mode_count == 11'd0)
            limit = 11'd1;
        else if (mode_count > 11'd1024)
            limit = 11'd1024;
        else
            limit = mode_count;
        count = 11'(modes_done_reg) + 11'd1;
        lastmode = count >= limit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsum_reg <= '0;
            ksum_reg <= '0;
            msum_reg <= '0;
            worst_mag_reg <= '0;
            worst_seen_reg <= 1'b0;
            worst_idx_reg <= '0;
            row_idx_reg <= '0;
            modes_done_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc_go && s2_last_reg)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && sum_ready)
                out_valid_reg <= 1'b0;
            if (acc_go)
            begin
                if (s2_last_reg)
                begin
                    rsum_reg <= '0;
                    ksum_reg <= '0;
                    msum_reg <= '0;
                    worst_mag_reg <= '0;
                    worst_seen_reg <= 1'b0;
                    worst_idx_reg <= '0;
                    row_idx_reg <= '0;
                    modes_done_reg <= lastmode ? 10'd0 : count[9:0];
                end
                else
                begin
                    rsum_reg <= rsum_n;
                    ksum_reg <= ksum_n;
                    msum_reg <= msum_n;
                    if (take_worst)
                    begin
                        worst_seen_reg <= 1'b1;
                        worst_mag_reg <= rsat;
                        worst_idx_reg <= row_idx_reg;
                    end
                    if (row_idx_reg != RowW'(MaxRows - 1))
                        row_idx_reg <= row_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_go && s2_last_reg)
        begin
            out_reg.residual_sum  <= rsum_n;
            out_reg.stiffness_sum <= ksum_n;
            out_reg.mass_sum      <= msum_n;
            out_reg.lambda_mag    <= s2_lmag_reg;
            out_reg.worst_index   <= take_worst ? row_idx_reg : worst_idx_reg;
            out_reg.last_mode     <= lastmode;
        end
    end

    assign sum_valid = out_valid_reg;
    assign sum_data = out_reg;

    ap_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_go && !s2_last_reg) |=> (rsum_reg >= $past(rsum_reg)))
        else $error("residual sum decreased within a mode");
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !sum_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending mode summary changed");
    ap_row: assert property (@(posedge clk) disable iff (!rst_n)
        worst_seen_reg |-> (worst_idx_reg <= row_idx_reg))
        else $error("worst row beyond current row");
endmodule
`default_nettype wire

// ----- src/erni_queue.sv -----
// Short queue of mode summaries between the accumulator and the finisher.
`default_nettype none
module erni_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire erni_pkg::mode_sum_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output erni_pkg::mode_sum_t  out_data
);
    import erni_pkg::*;

    mode_sum_t entry_reg [QueueDepth];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic push, pop;

    assign in_ready = fill_reg != 2'(QueueDepth);
    assign out_valid = fill_reg != 2'd0;
    assign out_data = entry_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_data;
    end

    ap_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'(QueueDepth))
        else $error("queue overfilled");
    ap_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0 || fill_reg == 2'(QueueDepth)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers inconsistent");
    ap_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("queue dropped an entry");
endmodule
`default_nettype wire

// ----- src/erni_finish.sv -----
// Back part: square roots, backward error division and result register.
`default_nettype none
module erni_finish (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            sum_valid,
    output logic                 sum_ready,
    input  wire erni_pkg::mode_sum_t sum_data,
    output logic                 valid,
    input  wire logic            ready,
    output logic [31:0]          residual_norm,
    output logic [31:0]          stiffness_norm,
    output logic [31:0]          mass_norm,
    output logic [16:0]          normalized_residual,
    output logic [11:0]          worst_row,
    output logic                 last_mode
);
    import erni_pkg::*;

    fin_state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    // Three bitwise square roots run side by side.
    logic [63:0] rad_reg [3];
    logic [63:0] rem_reg [3];
    logic [31:0] root_reg [3];
    logic [31:0] lam_reg;
    logic [RowW-1:0] widx_reg;
    logic        lmode_reg;
    logic [63:0] den_reg, drem_reg;
    logic [16:0] q_reg;
    logic [63:0] num;

    logic [65:0] trial [3];
    logic [65:0] rem_sh [3];
    logic [64:0] dd;
    logic        load;

    assign num = {root_reg[0], 16'd0};
    assign sum_ready = state_reg == FIN_IDLE;
    assign load = sum_valid && sum_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_sh[i] = {rem_reg[i], rad_reg[i][63:62]};
            trial[i] = {32'd0, root_reg[i], 2'b01};
        end
        dd = 65'(drem_reg) - 65'(den_reg - drem_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        case (state_reg)
            FIN_IDLE:
                if (sum_valid)
                begin
                    state_next = FIN_SQRT;
                    step_next = '0;
                end
            FIN_SQRT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd31)
                    state_next = FIN_MUL;
            end
            FIN_MUL:
            begin
                state_next = FIN_DIV;
                step_next = '0;
            end
            FIN_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (den_reg == '0 || num >= den_reg || step_reg == 5'd15)
                    state_next = FIN_OUT;
            end
            FIN_OUT:
                if (ready)
                    state_next = FIN_IDLE;
            default:
                state_next = FIN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FIN_IDLE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rad_reg[0] <= sum_data.residual_sum;
            rad_reg[1] <= sum_data.stiffness_sum;
            rad_reg[2] <= sum_data.mass_sum;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= '0;
                root_reg[i] <= '0;
            end
            lam_reg <= sum_data.lambda_mag;
            widx_reg <= sum_data.worst_index;
            lmode_reg <= sum_data.last_mode;
        end
        else if (state_reg == FIN_SQRT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rad_reg[i] <= {rad_reg[i][61:0], 2'b00};
                if (rem_sh[i] >= trial[i])
                begin
                    rem_reg[i] <= 64'(rem_sh[i] - trial[i]);
                    root_reg[i] <= {root_reg[i][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= 64'(rem_sh[i]);
                    root_reg[i] <= {root_reg[i][30:0], 1'b0};
                end
            end
        end
        else if (state_reg == FIN_MUL)
        begin
            den_reg <= {root_reg[1], 16'd0} + 64'(lam_reg) * 64'(root_reg[2]);
            drem_reg <= num;
            q_reg <= '0;
        end
        else if (state_reg == FIN_DIV)
        begin
            if (den_reg == '0)
                q_reg <= '0;
            else if (num >= den_reg)
                q_reg <= 17'd65536;
            else if (!dd[64])
            begin
                drem_reg <= dd[63:0];
                q_reg <= {q_reg[15:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[62:0], 1'b0};
                q_reg <= {q_reg[15:0], 1'b0};
            end
        end
    end

    assign valid = state_reg == FIN_OUT;
    assign residual_norm = root_reg[0];
    assign stiffness_norm = root_reg[1];
    assign mass_norm = root_reg[2];
    assign normalized_residual = q_reg;
    assign worst_row = 12'(widx_reg);
    assign last_mode = lmode_reg;

    ap_q: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (q_reg <= 17'd65536))
        else $error("backward error above one");
    ap_out: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=> (valid && $stable(q_reg)))
        else $error("result changed while stalled");
    ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FIN_SQRT) |-> !sum_ready)
        else $error("summary taken while busy");
endmodule
`default_nettype wire

// ----- src/eigenpair_residual_norms.sv -----
// Top level of the eigenpair residual norm block.
// Rows are taken one per cycle, while in_ready is high, into a three-stage
// accumulator (products, rounded residual magnitude, then saturating sums). Each
// row marked last pushes a mode summary into a two-entry queue; the back end
// takes it, runs three bitwise square roots, forms the denominator product, runs
// the backward error division and then presents the result until it is taken.
// Modes shorter than the back end's work on one summary therefore throttle the row
// stream once the queue is full; longer modes stream at one row per cycle.
// mode_count may be written only while the block is idle.
`default_nettype none
module eigenpair_residual_norms (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [10:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] stiffness_action,
    input  wire logic signed [31:0] mass_action,
    input  wire logic signed [31:0] eigenvalue,
    input  wire logic               last_row,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             residual_norm,
    output logic [31:0]             stiffness_norm,
    output logic [31:0]             mass_norm,
    output logic [16:0]             normalized_residual,
    output logic [11:0]             worst_row,
    output logic                    last_mode
);
    import erni_pkg::*;

    logic [10:0] mode_count_reg;
    logic a_valid, a_ready, q_valid, q_ready;
    mode_sum_t a_data, q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_count_reg <= 11'd1;
        else if (cfg_we)
            mode_count_reg <= cfg_wdata;
    end

    erni_accum u_accum (
        .clk, .rst_n,
        .row_valid(in_valid), .row_ready(in_ready),
        .stiffness_action, .mass_action, .eigenvalue, .last_row,
        .mode_count(mode_count_reg),
        .sum_valid(a_valid), .sum_ready(a_ready), .sum_data(a_data)
    );

    erni_queue u_queue (
        .clk, .rst_n,
        .in_valid(a_valid), .in_ready(a_ready), .in_data(a_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    erni_finish u_finish (
        .clk, .rst_n,
        .sum_valid(q_valid), .sum_ready(q_ready), .sum_data(q_data),
        .valid(out_valid), .ready(out_ready),
        .residual_norm, .stiffness_norm, .mass_norm,
        .normalized_residual, .worst_row, .last_mode
    );
endmodule
`default_nettype wire
